// ===== hw/rtl/lob_pkg.sv =====
package lob_pkg;

  // item kinds
  localparam logic [2:0] KindAdd      = 3'd0;
  localparam logic [2:0] KindCancel   = 3'd1;
  localparam logic [2:0] KindModify   = 3'd2;
  localparam logic [2:0] KindDecrease = 3'd3;
  localparam logic [2:0] KindQuery    = 3'd4;

  // result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNotFound = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;
  localparam logic [1:0] StatusDup      = 2'd3;

  localparam logic [29:0] TotalMax   = 30'h3FFF_FFFF;
  localparam logic [6:0]  MaxResults = 7'd64;
  localparam logic [6:0]  LiveMax    = 7'd127;

  typedef struct packed {
    logic [15:0] key;
    logic        side;
    logic [23:0] price;
    logic [23:0] qty;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    MODE_LOOKUP,
    MODE_SUMMARY,
    MODE_MATCH
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_APPLY,
    S_SUMMARY,
    S_MATCH,
    S_MDEC,
    S_MCHK,
    S_FINAL
  } state_e;

  typedef struct packed {
    logic  load;
    logic  scan_start;
    mode_e start_mode;
    mode_e proc_mode;
    logic  apply;
    logic  take_best;
    logic  emit_final;
  } cmd_t;

  typedef struct packed {
    logic       scan_done;
    logic       out_free;
    logic [2:0] kind;
    logic       qty_zero;
    logic       best_v;
    logic       pend_v;
    logic       covered;
  } stat_t;

endpackage

// ===== hw/rtl/lob_ctrl.sv =====
module lob_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lob_pkg::stat_t stat_i,
  output lob_pkg::cmd_t  cmd_o
);

  lob_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lob_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d           = state_q;
    in_stall_o        = 1'b1;
    cmd_o.load        = 1'b0;
    cmd_o.scan_start  = 1'b0;
    cmd_o.start_mode  = lob_pkg::MODE_SUMMARY;
    cmd_o.proc_mode   = lob_pkg::MODE_SUMMARY;
    cmd_o.apply       = 1'b0;
    cmd_o.take_best   = 1'b0;
    cmd_o.emit_final  = 1'b0;
    case (state_q)
      lob_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = 1'b1;
          if (stat_i.kind inside {lob_pkg::KindAdd, lob_pkg::KindCancel,
                                  lob_pkg::KindModify, lob_pkg::KindDecrease}) begin
            cmd_o.start_mode = lob_pkg::MODE_LOOKUP;
            state_d          = lob_pkg::S_LOOKUP;
          end else begin
            state_d = lob_pkg::S_SUMMARY;
          end
        end
      end
      lob_pkg::S_LOOKUP: begin
        cmd_o.proc_mode = lob_pkg::MODE_LOOKUP;
        if (stat_i.scan_done) begin
          state_d = lob_pkg::S_APPLY;
        end
      end
      lob_pkg::S_APPLY: begin
        cmd_o.apply      = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = lob_pkg::S_SUMMARY;
      end
      lob_pkg::S_SUMMARY: begin
        if (stat_i.scan_done) begin
          if (stat_i.kind == lob_pkg::KindQuery && !stat_i.qty_zero) begin
            cmd_o.scan_start = 1'b1;
            cmd_o.start_mode = lob_pkg::MODE_MATCH;
            state_d          = lob_pkg::S_MATCH;
          end else begin
            state_d = lob_pkg::S_FINAL;
          end
        end
      end
      lob_pkg::S_MATCH: begin
        cmd_o.proc_mode = lob_pkg::MODE_MATCH;
        if (stat_i.scan_done) begin
          state_d = lob_pkg::S_MDEC;
        end
      end
      lob_pkg::S_MDEC: begin
        if (!stat_i.best_v) begin
          state_d = lob_pkg::S_FINAL;
        end else if (!stat_i.pend_v || stat_i.out_free) begin
          cmd_o.take_best = 1'b1;
          state_d         = lob_pkg::S_MCHK;
        end
      end
      lob_pkg::S_MCHK: begin
        if (stat_i.covered) begin
          state_d = lob_pkg::S_FINAL;
        end else begin
          cmd_o.scan_start = 1'b1;
          cmd_o.start_mode = lob_pkg::MODE_MATCH;
          state_d          = lob_pkg::S_MATCH;
        end
      end
      lob_pkg::S_FINAL: begin
        if (stat_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = lob_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lob_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/lob_dp.sv =====
module lob_dp #(
  parameter int ORDER_SLOTS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lob_pkg::cmd_t  cmd_i,
  output lob_pkg::stat_t stat_o,
  input  logic [2:0]     kind_i,
  input  logic [15:0]    order_id_i,
  input  logic           is_sell_i,
  input  logic           is_market_i,
  input  logic [23:0]    price_i,
  input  logic [23:0]    quantity_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     status_o,
  output logic [23:0]    new_quantity_o,
  output logic [15:0]    matched_id_o,
  output logic           matched_valid_o,
  output logic           can_match_o,
  output logic           last_o,
  output logic [23:0]    best_bid_price_o,
  output logic [29:0]    best_bid_total_o,
  output logic [23:0]    best_ask_price_o,
  output logic [29:0]    best_ask_total_o,
  output logic [6:0]     live_orders_o
);

  localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CW = $clog2(ORDER_SLOTS + 1);
  localparam logic [IW-1:0] LastIx = IW'(ORDER_SLOTS - 1);

  // held item
  logic [2:0]  kind_q;
  logic [15:0] id_q;
  logic        sell_q, mkt_q;
  logic [23:0] price_q, qty_q;

  // slot store
  lob_pkg::entry_t mem [ORDER_SLOTS];
  lob_pkg::entry_t rd_q;
  logic [ORDER_SLOTS-1:0] live_q, used_q;
  logic [31:0] arr_q;
  logic [CW-1:0] cnt_q;

  // scan sequencer
  logic [IW-1:0] ix_q, p_ix_q;
  logic          iss_q, p_v_q;

  // lookup results
  logic            found_q, free_v_q;
  logic [IW-1:0]   found_ix_q, free_ix_q;
  lob_pkg::entry_t fent_q;

  // book summary
  logic        bany_q, aany_q;
  logic [23:0] bbp_q, bap_q;
  logic [29:0] bbt_q, bat_q;

  // match walk
  logic          best_v_q, pend_v_q;
  logic [IW-1:0] bix_q;
  logic [15:0]   bkey_q, pend_id_q;
  logic [23:0]   bprice_q, bqty_q;
  logic [31:0]   bage_q;
  logic [25:0]   cov_q;
  logic [6:0]    nmatch_q;

  // result fields of the item
  logic [1:0]  status_q;
  logic [23:0] newq_q;

  logic        p_live, p_used, opp, elig, better;
  logic [31:0] age;
  logic [30:0] bsum, asum;
  logic [23:0] dec_qty;
  logic        can;
  logic [CW+6:0] cnt_ext;

  logic            we;
  logic [IW-1:0]   wa;
  lob_pkg::entry_t wd;
  logic            clr, inc;
  logic [IW-1:0]   clr_ix;

  assign p_live = live_q[p_ix_q];
  assign p_used = used_q[p_ix_q];
  assign opp    = ~sell_q;
  assign age    = arr_q - rd_q.stamp;

  // eligibility and ranking of the slot under scan
  always_comb begin
    elig = p_live && !p_used && (rd_q.side == opp);
    if (!mkt_q) begin
      if (opp) begin
        elig = elig && (rd_q.price <= price_q);
      end else begin
        elig = elig && (rd_q.price >= price_q);
      end
    end
    if (rd_q.price != bprice_q) begin
      better = opp ? (rd_q.price < bprice_q) : (rd_q.price > bprice_q);
    end else begin
      better = age > bage_q;
    end
  end

  assign bsum    = {1'b0, bbt_q} + {7'b0, rd_q.qty};
  assign asum    = {1'b0, bat_q} + {7'b0, rd_q.qty};
  assign dec_qty = (fent_q.qty > qty_q) ? (fent_q.qty - qty_q) : 24'd0;

  // crossing test against the opposite best
  always_comb begin
    can = 1'b0;
    if (kind_q == lob_pkg::KindQuery) begin
      if (opp) begin
        can = aany_q && (mkt_q || bap_q <= price_q);
      end else begin
        can = bany_q && (mkt_q || bbp_q >= price_q);
      end
    end
  end

  // update decode for the apply step
  always_comb begin
    we     = 1'b0;
    wa     = free_ix_q;
    wd     = fent_q;
    clr    = 1'b0;
    inc    = 1'b0;
    clr_ix = found_ix_q;
    if (cmd_i.apply) begin
      case (kind_q)
        lob_pkg::KindAdd: begin
          if (!found_q && free_v_q) begin
            we  = 1'b1;
            inc = 1'b1;
            wd  = '{key: id_q, side: sell_q, price: price_q, qty: qty_q, stamp: arr_q};
          end
        end
        lob_pkg::KindCancel: begin
          clr = found_q;
        end
        lob_pkg::KindModify: begin
          wa     = found_ix_q;
          wd.qty = qty_q;
          if (found_q) begin
            if (qty_q == 24'd0) begin
              clr = 1'b1;
            end else begin
              we = 1'b1;
            end
          end
        end
        lob_pkg::KindDecrease: begin
          wa     = found_ix_q;
          wd.qty = dec_qty;
          if (found_q) begin
            if (dec_qty == 24'd0) begin
              clr = 1'b1;
            end else begin
              we = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ix_q];
  end

  // scan sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q  <= 1'b0;
      p_v_q  <= 1'b0;
      ix_q   <= '0;
      p_ix_q <= '0;
    end else begin
      p_v_q  <= iss_q;
      p_ix_q <= ix_q;
      if (cmd_i.scan_start) begin
        ix_q  <= '0;
        iss_q <= 1'b1;
      end else if (iss_q) begin
        if (ix_q == LastIx) begin
          iss_q <= 1'b0;
        end else begin
          ix_q <= ix_q + 1'b1;
        end
      end
    end
  end

  // book state: live bits, arrival counter, order count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      arr_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (inc) begin
        live_q[free_ix_q] <= 1'b1;
        arr_q             <= arr_q + 32'd1;
        cnt_q             <= cnt_q + 1'b1;
      end
      if (clr) begin
        live_q[clr_ix] <= 1'b0;
        cnt_q          <= cnt_q - 1'b1;
      end
    end
  end

  // item latch, lookup, summary and match accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= '0;
      found_q  <= 1'b0;
      free_v_q <= 1'b0;
      bany_q   <= 1'b0;
      aany_q   <= 1'b0;
      best_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      used_q   <= '0;
      cov_q    <= '0;
      nmatch_q <= '0;
      status_q <= lob_pkg::StatusOk;
      newq_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        kind_q   <= kind_i;
        id_q     <= order_id_i;
        sell_q   <= is_sell_i;
        mkt_q    <= is_market_i;
        price_q  <= price_i;
        qty_q    <= quantity_i;
        used_q   <= '0;
        pend_v_q <= 1'b0;
        cov_q    <= '0;
        nmatch_q <= '0;
        status_q <= lob_pkg::StatusOk;
        newq_q   <= '0;
      end
      // clear accumulators of the pass being started
      if (cmd_i.scan_start) begin
        case (cmd_i.start_mode)
          lob_pkg::MODE_LOOKUP: begin
            found_q  <= 1'b0;
            free_v_q <= 1'b0;
          end
          lob_pkg::MODE_MATCH: begin
            best_v_q <= 1'b0;
          end
          default: begin
            bany_q <= 1'b0;
            aany_q <= 1'b0;
            bbp_q  <= '0;
            bap_q  <= '0;
            bbt_q  <= '0;
            bat_q  <= '0;
          end
        endcase
      end
      // fold in the slot under scan
      if (p_v_q) begin
        case (cmd_i.proc_mode)
          lob_pkg::MODE_LOOKUP: begin
            if (p_live && rd_q.key == id_q && !found_q) begin
              found_q    <= 1'b1;
              found_ix_q <= p_ix_q;
              fent_q     <= rd_q;
            end
            if (!p_live && !free_v_q) begin
              free_v_q  <= 1'b1;
              free_ix_q <= p_ix_q;
            end
          end
          lob_pkg::MODE_MATCH: begin
            if (elig && (!best_v_q || better)) begin
              best_v_q <= 1'b1;
              bix_q    <= p_ix_q;
              bkey_q   <= rd_q.key;
              bprice_q <= rd_q.price;
              bqty_q   <= rd_q.qty;
              bage_q   <= age;
            end
          end
          default: begin
            if (p_live && !rd_q.side) begin
              if (!bany_q || rd_q.price > bbp_q) begin
                bany_q <= 1'b1;
                bbp_q  <= rd_q.price;
                bbt_q  <= {6'b0, rd_q.qty};
              end else if (rd_q.price == bbp_q) begin
                bbt_q <= (bsum > {1'b0, lob_pkg::TotalMax}) ? lob_pkg::TotalMax : bsum[29:0];
              end
            end
            if (p_live && rd_q.side) begin
              if (!aany_q || rd_q.price < bap_q) begin
                aany_q <= 1'b1;
                bap_q  <= rd_q.price;
                bat_q  <= {6'b0, rd_q.qty};
              end else if (rd_q.price == bap_q) begin
                bat_q <= (asum > {1'b0, lob_pkg::TotalMax}) ? lob_pkg::TotalMax : asum[29:0];
              end
            end
          end
        endcase
      end
      // status of the update
      if (cmd_i.apply) begin
        if (kind_q == lob_pkg::KindAdd) begin
          if (found_q) begin
            status_q <= lob_pkg::StatusDup;
          end else if (!free_v_q) begin
            status_q <= lob_pkg::StatusFull;
          end
        end else if (!found_q) begin
          status_q <= lob_pkg::StatusNotFound;
        end else if (kind_q == lob_pkg::KindDecrease) begin
          newq_q <= dec_qty;
        end
      end
      // take the chosen order as the new pending match
      if (cmd_i.take_best) begin
        used_q[bix_q] <= 1'b1;
        pend_v_q      <= 1'b1;
        pend_id_q     <= bkey_q;
        cov_q         <= cov_q + {2'b0, bqty_q};
        nmatch_q      <= nmatch_q + 7'd1;
      end
    end
  end

  // output register
  assign cnt_ext = {7'b0, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_final || (cmd_i.take_best && pend_v_q)) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_final || (cmd_i.take_best && pend_v_q)) begin
      status_o         <= status_q;
      new_quantity_o   <= newq_q;
      matched_id_o     <= pend_v_q ? pend_id_q : 16'd0;
      matched_valid_o  <= pend_v_q;
      can_match_o      <= can;
      last_o           <= cmd_i.emit_final;
      best_bid_price_o <= bbp_q;
      best_bid_total_o <= bbt_q;
      best_ask_price_o <= bap_q;
      best_ask_total_o <= bat_q;
      live_orders_o    <= (cnt_ext > (CW + 7)'(lob_pkg::LiveMax)) ? lob_pkg::LiveMax
                                                                  : cnt_ext[6:0];
    end
  end

  // status to the controller
  assign stat_o.scan_done = p_v_q && (p_ix_q == LastIx);
  assign stat_o.out_free  = !out_valid_o || !out_stall_i;
  assign stat_o.kind      = cmd_i.load ? kind_i : kind_q;
  assign stat_o.qty_zero  = (qty_q == 24'd0);
  assign stat_o.best_v    = best_v_q;
  assign stat_o.pend_v    = pend_v_q;
  assign stat_o.covered   = ({2'b0, qty_q} <= cov_q) || (nmatch_q == lob_pkg::MaxResults);

endmodule

// ===== hw/rtl/limit_order_book_core.sv =====
// Limit order book with price-time priority over ORDER_SLOTS resting orders.
// Items are taken one at a time. Every item passes the slot store through its
// single read port once per scan, one slot a cycle: add, cancel, modify and
// decrease run a lookup scan, an update step and a summary scan; a query runs
// the summary scan and then one full scan per matched order, for at most 64
// matches. Results leave through an output register, so a stalled output only
// delays the next result. No clearing pass is needed after reset.
module limit_order_book_core #(
  parameter int ORDER_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] order_id_i,
  input  logic        is_sell_i,
  input  logic        is_market_i,
  input  logic [23:0] price_i,
  input  logic [23:0] quantity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [23:0] new_quantity_o,
  output logic [15:0] matched_id_o,
  output logic        matched_valid_o,
  output logic        can_match_o,
  output logic        last_o,
  output logic [23:0] best_bid_price_o,
  output logic [29:0] best_bid_total_o,
  output logic [23:0] best_ask_price_o,
  output logic [29:0] best_ask_total_o,
  output logic [6:0]  live_orders_o
);

  lob_pkg::cmd_t  cmd;
  lob_pkg::stat_t stat;

  lob_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lob_dp #(
    .ORDER_SLOTS (ORDER_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .kind_i           (kind_i),
    .order_id_i       (order_id_i),
    .is_sell_i        (is_sell_i),
    .is_market_i      (is_market_i),
    .price_i          (price_i),
    .quantity_i       (quantity_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .new_quantity_o   (new_quantity_o),
    .matched_id_o     (matched_id_o),
    .matched_valid_o  (matched_valid_o),
    .can_match_o      (can_match_o),
    .last_o           (last_o),
    .best_bid_price_o (best_bid_price_o),
    .best_bid_total_o (best_bid_total_o),
    .best_ask_price_o (best_ask_price_o),
    .best_ask_total_o (best_ask_total_o),
    .live_orders_o    (live_orders_o)
  );

endmodule

// ===== hw/rtl/lob_chk.sv =====
module lob_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [15:0] matched_id_o,
  input logic        matched_valid_o,
  input logic        last_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(matched_id_o) && $stable(last_o))
    else $error("stalled result changed");

  // one item at a time: busy after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // a result without a match ends its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_valid_o |-> last_o)
    else $error("unmatched result not last");

  // matches only come from queries, which report ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && matched_valid_o |-> status_o == lob_pkg::StatusOk)
    else $error("match with error status");

endmodule

bind limit_order_book_core lob_chk u_lob_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .matched_id_o    (matched_id_o),
  .matched_valid_o (matched_valid_o),
  .last_o          (last_o)
);

// ===== tb/tb.sv =====
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          Slots       = 64;
  localparam int          StallLimit  = 20000;
  localparam logic [2:0]  KindSpareLo = 3'd5;
  localparam logic [2:0]  KindSpareHi = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] id;
    logic        sell;
    logic        mkt;
    logic [23:0] price;
    logic [23:0] qty;
  } order_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] new_qty;
    logic [15:0] m_id;
    logic        m_valid;
    logic        can;
    logic        is_last;
    logic [23:0] bid_px;
    logic [29:0] bid_tot;
    logic [23:0] ask_px;
    logic [29:0] ask_tot;
    logic [6:0]  live;
  } book_result_t;

  // directed row: item plus the status and order count known by inspection
  typedef struct {
    order_item_t it;
    bit          typed;
    logic [1:0]  status;
    logic [6:0]  live;
  } book_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = '0;
  logic [15:0] order_id_i = '0;
  logic        is_sell_i = 1'b0;
  logic        is_market_i = 1'b0;
  logic [23:0] price_i = '0;
  logic [23:0] quantity_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [23:0] new_quantity_o;
  logic [15:0] matched_id_o;
  logic        matched_valid_o;
  logic        can_match_o;
  logic        last_o;
  logic [23:0] best_bid_price_o;
  logic [29:0] best_bid_total_o;
  logic [23:0] best_ask_price_o;
  logic [29:0] best_ask_total_o;
  logic [6:0]  live_orders_o;

  limit_order_book_core #(.ORDER_SLOTS(Slots)) u_top (.*);

  always #5 clk_i = ~clk_i;

  // shadow book
  bit          bk_live[Slots];
  logic [15:0] bk_key[Slots];
  logic        bk_side[Slots];
  logic [23:0] bk_price[Slots];
  logic [23:0] bk_qty[Slots];
  logic [31:0] bk_stamp[Slots];
  logic [31:0] bk_arrival;

  book_result_t fills_q[$];
  int  errors, n_items, n_fills, n_matched, n_full, n_capped;
  int  tx_pct, rx_pct, hold_cnt;

  function automatic int find_key(logic [15:0] id);
    for (int i = 0; i < Slots; i++)
      if (bk_live[i] && bk_key[i] == id) return i;
    return -1;
  endfunction

  function automatic bit best_of(logic side, output logic [23:0] px,
                                 output logic [29:0] tot);
    bit           any;
    logic [23:0]  bp;
    longint       sum;
    any = 0;
    bp  = '0;
    sum = 0;
    for (int i = 0; i < Slots; i++) begin
      if (!bk_live[i] || bk_side[i] != side) continue;
      if (!any || (side ? bk_price[i] < bp : bk_price[i] > bp)) begin
        any = 1;
        bp  = bk_price[i];
        sum = 0;
      end
      if (bk_price[i] == bp) sum += bk_qty[i];
    end
    px  = bp;
    tot = (sum > longint'(lob_pkg::TotalMax)) ? lob_pkg::TotalMax : sum[29:0];
    return any;
  endfunction

  // apply one item to the shadow book and queue the fills it causes
  function automatic int book_apply(order_item_t it);
    logic [1:0]   st;
    logic [23:0]  nq, op;
    logic [29:0]  ot;
    logic         can, opp;
    bit           has, used[Slots];
    logic [15:0]  ids[$];
    longint       covered;
    int           s, best, nres, live;
    book_result_t r;
    st = lob_pkg::StatusOk;
    nq = '0;
    can = 1'b0;
    opp = ~it.sell;
    covered = 0;
    live = 0;
    if (it.kind == lob_pkg::KindAdd) begin
      s = -1;
      for (int i = Slots - 1; i >= 0; i--) if (!bk_live[i]) s = i;
      if (find_key(it.id) >= 0) st = lob_pkg::StatusDup;
      else if (s < 0) st = lob_pkg::StatusFull;
      else begin
        bk_live[s]  = 1;
        bk_key[s]   = it.id;
        bk_side[s]  = it.sell;
        bk_price[s] = it.price;
        bk_qty[s]   = it.qty;
        bk_stamp[s] = bk_arrival;
        bk_arrival++;
      end
    end else if (it.kind inside {lob_pkg::KindCancel, lob_pkg::KindModify,
                                 lob_pkg::KindDecrease}) begin
      s = find_key(it.id);
      if (s < 0) st = lob_pkg::StatusNotFound;
      else if (it.kind == lob_pkg::KindCancel) bk_live[s] = 0;
      else if (it.kind == lob_pkg::KindModify) begin
        if (it.qty == 0) bk_live[s] = 0;
        else bk_qty[s] = it.qty;
      end else begin
        nq = (bk_qty[s] > it.qty) ? bk_qty[s] - it.qty : '0;
        if (nq == 0) bk_live[s] = 0;
        else bk_qty[s] = nq;
      end
    end else if (it.kind == lob_pkg::KindQuery) begin
      has = best_of(opp, op, ot);
      if (it.mkt) can = has;
      else if (has) can = opp ? (op <= it.price) : (op >= it.price);
      foreach (used[i]) used[i] = 0;
      // walk opposite side in price, then age order
      while (covered < longint'(it.qty) && ids.size() < lob_pkg::MaxResults) begin
        best = -1;
        for (int i = 0; i < Slots; i++) begin
          if (!bk_live[i] || used[i] || bk_side[i] != opp) continue;
          if (!it.mkt && (opp ? bk_price[i] > it.price : bk_price[i] < it.price))
            continue;
          if (best < 0) best = i;
          else if (bk_price[i] != bk_price[best]) begin
            if (opp ? bk_price[i] < bk_price[best] : bk_price[i] > bk_price[best])
              best = i;
          end else if (32'(bk_arrival - bk_stamp[i]) >
                       32'(bk_arrival - bk_stamp[best]))
            best = i;
        end
        if (best < 0) break;
        used[best] = 1;
        ids = {ids, bk_key[best]};
        covered += bk_qty[best];
      end
    end
    void'(best_of(1'b0, r.bid_px, r.bid_tot));
    void'(best_of(1'b1, r.ask_px, r.ask_tot));
    foreach (bk_live[i]) live += bk_live[i];
    r.live    = (live > lob_pkg::LiveMax) ? lob_pkg::LiveMax : 7'(live);
    r.status  = st;
    r.new_qty = nq;
    r.can     = can;
    r.m_valid = ids.size() > 0;
    nres = (ids.size() > 0) ? ids.size() : 1;
    if (st == lob_pkg::StatusFull) n_full++;
    if (ids.size() == lob_pkg::MaxResults) n_capped++;
    for (int k = 0; k < nres; k++) begin
      r.m_id    = (ids.size() > 0) ? ids[k] : '0;
      r.is_last = (k == nres - 1);
      fills_q = {fills_q, r};
    end
    return nres;
  endfunction

  // offer one item, hold it until the transfer, then update the shadow book
  task automatic send(order_item_t it, output book_result_t first);
    int n;
    if ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= it.kind;
    order_id_i  <= it.id;
    is_sell_i   <= it.sell;
    is_market_i <= it.mkt;
    price_i     <= it.price;
    quantity_i  <= it.qty;
    do @(posedge clk_i); while (in_stall_o);
    n = fills_q.size();
    void'(book_apply(it));
    first = fills_q[n];
    n_items++;
  endtask

  task automatic send_only(order_item_t it);
    book_result_t dummy;
    send(it, dummy);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (fills_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic order_item_t mk(logic [2:0] k, logic [15:0] id, logic sell,
                                     logic mkt, logic [23:0] px, logic [23:0] q);
    order_item_t it;
    it = '{kind: k, id: id, sell: sell, mkt: mkt, price: px, qty: q};
    return it;
  endfunction

  // mostly well-formed order flow on a small id pool near one price
  function automatic order_item_t rand_item();
    order_item_t it;
    int sel;
    sel = $urandom_range(99);
    it.kind  = (sel < 40) ? lob_pkg::KindAdd : (sel < 50) ? lob_pkg::KindCancel :
               (sel < 60) ? lob_pkg::KindModify : (sel < 72) ? lob_pkg::KindDecrease :
               (sel < 96) ? lob_pkg::KindQuery : 3'($urandom_range(7));
    it.id    = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    it.sell  = $urandom_range(1);
    it.mkt   = ($urandom_range(3) == 0);
    it.price = ($urandom_range(9) == 0) ? 24'($urandom) : 24'(1000 + $urandom_range(20));
    it.qty   = ($urandom_range(9) == 0) ? 24'($urandom) :
               ($urandom_range(14) == 0) ? '0 : 24'($urandom_range(1, 300));
    return it;
  endfunction

  task automatic chk(string name, longint exp, longint act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  // compare every result transfer with the oldest expectation
  always @(posedge clk_i) begin
    book_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fills_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = fills_q.pop_front();
        n_fills++;
        if (matched_valid_o) n_matched++;
        chk("status", e.status, status_o);
        chk("new_quantity", e.new_qty, new_quantity_o);
        chk("matched_id", e.m_id, matched_id_o);
        chk("matched_valid", e.m_valid, matched_valid_o);
        chk("can_match", e.can, can_match_o);
        chk("last", e.is_last, last_o);
        chk("best_bid_price", e.bid_px, best_bid_price_o);
        chk("best_bid_total", e.bid_tot, best_bid_total_o);
        chk("best_ask_price", e.ask_px, best_ask_price_o);
        chk("best_ask_total", e.ask_tot, best_ask_total_o);
        chk("live_orders", e.live, live_orders_o);
      end
    end
  end

  // receiver stall: long hold-off first, else random
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_pct);
    end
  end

  // stop when no transfer happens for too long
  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else if (rst_ni) quiet++;
    if (quiet > StallLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    book_row_t    rows[$];
    book_result_t first;
    hold_cnt   = 0;
    tx_pct     = 0;
    rx_pct     = 0;
    errors     = 0;
    n_items    = 0;
    n_fills    = 0;
    n_matched  = 0;
    n_full     = 0;
    n_capped   = 0;
    bk_arrival = '0;
    foreach (bk_live[i]) bk_live[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      '{mk(lob_pkg::KindQuery, 0, 0, 1, 0, 24'hFFFFFF), 1, lob_pkg::StatusOk, 0},
      '{mk(lob_pkg::KindCancel, 5, 0, 0, 0, 0), 1, lob_pkg::StatusNotFound, 0},
      '{mk(lob_pkg::KindModify, 5, 0, 0, 0, 9), 1, lob_pkg::StatusNotFound, 0},
      '{mk(lob_pkg::KindDecrease, 5, 0, 0, 0, 9), 1, lob_pkg::StatusNotFound, 0},
      '{mk(lob_pkg::KindAdd, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF), 1, lob_pkg::StatusOk, 1},
      '{mk(lob_pkg::KindAdd, 16'hFFFF, 1, 0, 0, 0), 1, lob_pkg::StatusOk, 2},
      '{mk(lob_pkg::KindAdd, 0, 1, 0, 7, 7), 1, lob_pkg::StatusDup, 2},
      '{mk(lob_pkg::KindAdd, 1, 0, 0, 24'hFFFFFF, 24'hFFFFFF), 1, lob_pkg::StatusOk, 3},
      '{mk(lob_pkg::KindAdd, 2, 1, 0, 500, 40), 1, lob_pkg::StatusOk, 4},
      '{mk(lob_pkg::KindAdd, 3, 1, 0, 500, 60), 1, lob_pkg::StatusOk, 5},
      '{mk(lob_pkg::KindQuery, 0, 0, 0, 500, 70), 0, lob_pkg::StatusOk, 0},
      '{mk(lob_pkg::KindQuery, 0, 0, 0, 499, 70), 0, lob_pkg::StatusOk, 0},
      '{mk(lob_pkg::KindQuery, 0, 1, 1, 0, 24'hFFFFFF), 0, lob_pkg::StatusOk, 0},
      '{mk(lob_pkg::KindQuery, 0, 1, 0, 24'hFFFFFF, 0), 0, lob_pkg::StatusOk, 0},
      '{mk(lob_pkg::KindModify, 2, 0, 0, 0, 24'hFFFFFF), 1, lob_pkg::StatusOk, 5},
      '{mk(lob_pkg::KindDecrease, 2, 0, 0, 0, 5), 1, lob_pkg::StatusOk, 5},
      '{mk(lob_pkg::KindDecrease, 3, 0, 0, 0, 24'hFFFFFF), 1, lob_pkg::StatusOk, 4},
      '{mk(lob_pkg::KindModify, 16'hFFFF, 0, 0, 0, 0), 1, lob_pkg::StatusOk, 3},
      '{mk(KindSpareLo, 9, 1, 1, 24'hFFFFFF, 24'hFFFFFF), 1, lob_pkg::StatusOk, 3},
      '{mk(KindSpareHi, 9, 0, 0, 0, 0), 1, lob_pkg::StatusOk, 3},
      '{mk(lob_pkg::KindCancel, 0, 0, 0, 0, 0), 1, lob_pkg::StatusOk, 2},
      '{mk(lob_pkg::KindCancel, 1, 0, 0, 0, 0), 1, lob_pkg::StatusOk, 1},
      '{mk(lob_pkg::KindCancel, 2, 0, 0, 0, 0), 1, lob_pkg::StatusOk, 0}
    };
    // directed part, no idling
    foreach (rows[i]) begin
      send(rows[i].it, first);
      if (rows[i].typed) begin
        chk("row status", rows[i].status, first.status);
        chk("row live_orders", rows[i].live, first.live);
      end
    end
    drain();

    // fill the store, overflow it, then sweep it with a capped market query
    tx_pct = 30;
    rx_pct = 69;
    for (int i = 0; i < Slots; i++)
      send_only(mk(lob_pkg::KindAdd, 16'(100 + i), 1, 0, 24'(200 + i % 3), 24'(1 + i % 4)));
    send_only(mk(lob_pkg::KindAdd, 16'd999, 0, 0, 10, 10));
    send_only(mk(lob_pkg::KindQuery, 0, 0, 1, 0, 24'hFFFFFF));
    for (int i = 0; i < Slots; i++)
      send_only(mk(lob_pkg::KindCancel, 16'(100 + i), 0, 0, 0, 0));
    drain();

    // random phases with both idling patterns, then one with only a long receiver hold-off
    for (int ph = 0; ph < 3; ph++) begin
      tx_pct = (ph == 0) ? 30 : (ph == 1) ? 69 : 0;
      rx_pct = (ph == 0) ? 69 : (ph == 1) ? 30 : 0;
      if (ph == 2) hold_cnt = 800;
      for (int i = 0; i < 75; i++) send_only(rand_item());
      drain();
    end

    in_valid_i <= 1'b0;
    repeat (300) @(posedge clk_i);
    $display("covered %0d items, %0d results, %0d matches", n_items, n_fills, n_matched);
    $display("store-full rejects %0d, capped queries %0d", n_full, n_capped);
    if (errors == 0 && fills_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
